// ----- rtl/wps_pkg.sv -----
// shared widths, field layout and command codes for the windowed power statistics block
package wps_pkg;

    localparam int POWER_W     = 20;
    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 9;
    localparam int SAMPLE_W    = POWER_W + TIME_W;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 128;
    localparam int OUT_USED_W  = POWER_W + TIME_W + 3 * POWER_W + COUNT_W;

    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

endpackage

// ----- rtl/wps_ram.sv -----
// generic single write port ram with registered read
module wps_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/wps_div.sv -----
// restoring divider, one quotient bit per cycle
module wps_div #(
    parameter int DW = 29,
    parameter int VW = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [VW-1:0] r_rem, n_rem;
    logic [VW-1:0] r_div, n_div;
    logic [DW-1:0] r_quo, n_quo;
    logic [VW:0]   rem_sh;
    logic [VW:0]   trial;
    logic          q_bit;

    always_comb begin
        rem_sh = {r_rem, r_quo[DW-1]};
        trial  = rem_sh - {1'b0, r_div};
        q_bit  = (rem_sh >= {1'b0, r_div});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DW);
            n_rem  = '0;
            n_div  = i_divisor;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            n_rem = q_bit ? trial[VW-1:0] : rem_sh[VW-1:0];
            n_quo = {r_quo[DW-2:0], q_bit};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_div <= n_div;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/windowed_power_statistics.sv -----
// stores are accepted one per cycle while idle; a query walks the stored samples
// newest first with one ring read per cycle, up to the fill count (256 at most with
// the default depth), and takes the mean from a one-bit-per-cycle divider; not
// ready during a query
// synchronous active-low reset clears write pointer, fill count and window;
// the ring contents are not cleared and are only read once written
module windowed_power_statistics #(
    parameter int RING_DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wps_pkg::TIME_W-1:0]       i_cfg_wdata,     // window_ms
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [wps_pkg::IN_TDATA_W-1:0]   s_axis_tdata,    // time_ms, power, zero fill
    input  logic                             s_axis_tuser,    // cmd
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [wps_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,    // latest_power, latest_time_ms,
                                                              // max_power, min_power,
                                                              // average_power, window_count,
                                                              // zero fill
    output logic                             m_axis_tuser     // ring_empty
);
    import wps_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int SW = POWER_W + FW;
    localparam int XW = (FW > COUNT_W) ? FW : COUNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state              r_state, n_state;
    logic [TIME_W-1:0]   r_window, n_window;
    logic [AW-1:0]       r_wp, n_wp;
    logic [FW-1:0]       r_fill, n_fill;
    logic [AW-1:0]       r_addr, n_addr;
    logic [FW-1:0]       r_k, n_k;
    logic                r_dv, n_dv;
    logic                r_first, n_first;
    logic                r_empty, n_empty;
    logic [TIME_W-1:0]   r_qtime, n_qtime;
    logic [POWER_W-1:0]  r_newest, n_newest;
    logic [TIME_W-1:0]   r_ntime, n_ntime;
    logic [POWER_W-1:0]  r_mx, n_mx;
    logic [POWER_W-1:0]  r_mn, n_mn;
    logic [SW-1:0]       r_sum, n_sum;
    logic [FW-1:0]       r_cnt, n_cnt;

    logic                in_acc;
    logic                ram_we;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic [POWER_W-1:0]  rd_val;
    logic [TIME_W-1:0]   rd_time;
    logic                out_win;
    logic                walk_done;
    logic                div_start;
    logic                div_done;
    logic [SW-1:0]       div_quo;
    logic [AW-1:0]       wp_prev;
    logic [AW-1:0]       addr_prev;
    logic [POWER_W-1:0]  avg;
    logic [XW-1:0]       cnt_x;
    logic [OUT_USED_W-1:0] out_fields;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign ram_we    = in_acc && (t_cmd'(s_axis_tuser) == CMD_STORE);
    assign rd_time   = ram_rdata[TIME_W-1:0];
    assign rd_val    = ram_rdata[SAMPLE_W-1:TIME_W];
    // 33-bit window test, no wrap
    assign out_win   = (({1'b0, rd_time} + {1'b0, r_window}) < {1'b0, r_qtime});
    assign walk_done = (r_dv && out_win) || (!r_dv && (r_k >= r_fill));
    assign div_start = (r_state == ST_WALK) && walk_done && (r_cnt != '0);
    assign wp_prev   = (r_wp == '0) ? AW'(RING_DEPTH - 1) : r_wp - 1'b1;
    assign addr_prev = (r_addr == '0) ? AW'(RING_DEPTH - 1) : r_addr - 1'b1;

    wps_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata ({s_axis_tdata[SAMPLE_W-1:TIME_W], s_axis_tdata[TIME_W-1:0]}),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    wps_div #(
        .DW (SW),
        .VW (FW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state  = r_state;
        n_window = i_cfg_we ? i_cfg_wdata : r_window;
        n_wp     = r_wp;
        n_fill   = r_fill;
        n_addr   = r_addr;
        n_k      = r_k;
        n_dv     = r_dv;
        n_first  = r_first;
        n_empty  = r_empty;
        n_qtime  = r_qtime;
        n_newest = r_newest;
        n_ntime  = r_ntime;
        n_mx     = r_mx;
        n_mn     = r_mn;
        n_sum    = r_sum;
        n_cnt    = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (t_cmd'(s_axis_tuser) == CMD_STORE) begin
                        n_wp = (r_wp == AW'(RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                        if (r_fill < FW'(RING_DEPTH)) begin
                            n_fill = r_fill + 1'b1;
                        end
                    end else begin
                        n_qtime = s_axis_tdata[TIME_W-1:0];
                        if (r_fill == '0) begin
                            n_empty = 1'b1;
                            n_state = ST_OUT;
                        end else begin
                            n_empty = 1'b0;
                            n_addr  = wp_prev;
                            n_k     = '0;
                            n_dv    = 1'b0;
                            n_first = 1'b1;
                            n_sum   = '0;
                            n_cnt   = '0;
                            n_state = ST_WALK;
                        end
                    end
                end
            end
            ST_WALK: begin
                // read issue runs one slot ahead of the check
                if (r_k < r_fill) begin
                    n_addr = addr_prev;
                    n_k    = r_k + 1'b1;
                    n_dv   = 1'b1;
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    if (r_first) begin
                        n_first  = 1'b0;
                        n_newest = rd_val;
                        n_ntime  = rd_time;
                        n_mx     = rd_val;
                        n_mn     = rd_val;
                    end else if (!out_win) begin
                        if (rd_val > r_mx) begin
                            n_mx = rd_val;
                        end
                        if (rd_val < r_mn) begin
                            n_mn = rd_val;
                        end
                    end
                    if (!out_win) begin
                        n_sum = r_sum + SW'(rd_val);
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                if (walk_done) begin
                    n_state = (r_cnt != '0) ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_window <= '0;
            r_wp     <= '0;
            r_fill   <= '0;
            r_dv     <= 1'b0;
            r_first  <= 1'b0;
            r_empty  <= 1'b0;
            r_k      <= '0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_window <= n_window;
            r_wp     <= n_wp;
            r_fill   <= n_fill;
            r_dv     <= n_dv;
            r_first  <= n_first;
            r_empty  <= n_empty;
            r_k      <= n_k;
            r_cnt    <= n_cnt;
        end
        r_addr   <= n_addr;
        r_qtime  <= n_qtime;
        r_newest <= n_newest;
        r_ntime  <= n_ntime;
        r_mx     <= n_mx;
        r_mn     <= n_mn;
        r_sum    <= n_sum;
    end

    // empty window falls back to the newest value
    assign avg   = (r_cnt == '0) ? r_newest : div_quo[POWER_W-1:0];
    assign cnt_x = XW'(r_cnt);

    assign out_fields = {cnt_x[COUNT_W-1:0], avg, r_mn, r_mx, r_ntime, r_newest};

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = r_empty ? '0 : OUT_TDATA_W'(out_fields);
    assign m_axis_tuser  = r_empty;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// self-checking testbench for windowed_power_statistics: directed cases, then random traffic
module tb_top;
    import wps_pkg::*;

    localparam int DEPTH         = 256;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 5000;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_ITEMS   = 320;

    // result layout in m_axis_tdata
    localparam int LATEST_LO = 0;
    localparam int TSTAMP_LO = LATEST_LO + POWER_W;
    localparam int MAX_LO    = TSTAMP_LO + TIME_W;
    localparam int MIN_LO    = MAX_LO + POWER_W;
    localparam int AVG_LO    = MIN_LO + POWER_W;
    localparam int COUNT_LO  = AVG_LO + POWER_W;

    typedef struct packed {
        logic [POWER_W-1:0] latest_power;
        logic [TIME_W-1:0]  latest_time;
        logic [POWER_W-1:0] max_power;
        logic [POWER_W-1:0] min_power;
        logic [POWER_W-1:0] average_power;
        logic [COUNT_W-1:0] window_count;
        logic               ring_empty;
    } t_stats;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [TIME_W-1:0]      i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    // local copy of the sample ring and the window setting
    bit [POWER_W-1:0] ring_power [DEPTH];
    bit [TIME_W-1:0]  ring_time [DEPTH];
    bit [7:0]         ring_wr = '0;
    bit [COUNT_W-1:0] ring_fill = '0;
    bit [TIME_W-1:0]  window_ms = '0;

    t_stats pending_stats [$];
    int     mismatches = 0;
    int     quiet_cycles = 0;
    int     rx_hold = 0;
    bit     steady = 1'b0;

    windowed_power_statistics #(
        .RING_DEPTH(DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    function automatic void store_sample(input bit [TIME_W-1:0] t, input bit [POWER_W-1:0] p);
        ring_power[ring_wr] = p;
        ring_time[ring_wr]  = t;
        ring_wr++;
        if (ring_fill < DEPTH) begin
            ring_fill++;
        end
    endfunction

    function automatic t_stats window_stats(input bit [TIME_W-1:0] now);
        t_stats           r;
        bit [7:0]         slot;
        bit [63:0]        sum;
        int               n;
        bit               walking;
        bit [TIME_W:0]    reach;
        bit [POWER_W-1:0] v;
        r = '0;
        if (ring_fill == 0) begin
            r.ring_empty = 1'b1;
            return r;
        end
        slot = ring_wr - 8'd1;
        r.latest_power = ring_power[slot];
        r.latest_time  = ring_time[slot];
        r.max_power    = ring_power[slot];
        r.min_power    = ring_power[slot];
        sum     = 0;
        n       = 0;
        walking = 1'b1;
        // newest first, stopping at the first sample that has left the window
        while (walking && n < ring_fill) begin
            reach = {1'b0, ring_time[slot]} + {1'b0, window_ms};
            if (reach < {1'b0, now}) begin
                walking = 1'b0;
            end else begin
                v = ring_power[slot];
                if (v > r.max_power) r.max_power = v;
                if (v < r.min_power) r.min_power = v;
                sum  += 64'(v);
                n++;
                slot--;
            end
        end
        r.window_count  = COUNT_W'(n);
        r.average_power = (n == 0) ? r.latest_power : POWER_W'(sum / 64'(n));
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [TIME_W-1:0] want,
                                          input logic [TIME_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%0t: %s expected %h, got %h", $time, name, want, got);
            end
        end
    endfunction

    function automatic void check_result(input logic [OUT_TDATA_W-1:0] data, input logic flag);
        t_stats want;
        if (pending_stats.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%0t: result item with no query outstanding", $time);
            end
            return;
        end
        want = pending_stats.pop_front();
        compare_field("latest_power", TIME_W'(want.latest_power),
                      TIME_W'(data[LATEST_LO +: POWER_W]));
        compare_field("latest_time_ms", want.latest_time, data[TSTAMP_LO +: TIME_W]);
        compare_field("max_power", TIME_W'(want.max_power), TIME_W'(data[MAX_LO +: POWER_W]));
        compare_field("min_power", TIME_W'(want.min_power), TIME_W'(data[MIN_LO +: POWER_W]));
        compare_field("average_power", TIME_W'(want.average_power),
                      TIME_W'(data[AVG_LO +: POWER_W]));
        compare_field("window_count", TIME_W'(want.window_count),
                      TIME_W'(data[COUNT_LO +: COUNT_W]));
        compare_field("ring_empty", TIME_W'(want.ring_empty), TIME_W'(flag));
    endfunction

    // result side: check, then hold off for a random number of cycles, or none while steady
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            check_result(m_axis_tdata, m_axis_tuser);
            rx_hold = steady ? 0 : $urandom_range(0, 8);
        end else if (rx_hold > 0) begin
            rx_hold--;
        end
        m_axis_tready <= (rx_hold == 0);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            i_cfg_we || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("windowed_power_statistics: mismatch");
            $finish;
        end
    end

    task automatic send_item(input t_cmd cmd, input bit [TIME_W-1:0] t,
                             input bit [POWER_W-1:0] p);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - TIME_W - POWER_W){1'b0}}, p, t};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        if (cmd == CMD_STORE) begin
            store_sample(t, p);
        end else begin
            pending_stats.insert(pending_stats.size(), window_stats(t));
        end
    endtask

    // wait for all outstanding results; stores give no result, so also allow a few cycles after the last one
    task automatic settle;
        s_axis_tvalid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_window(input bit [TIME_W-1:0] w);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        window_ms = w;
    endtask

    task automatic test_empty_ring;
        send_item(CMD_QUERY, '0, '1);
        send_item(CMD_QUERY, '1, '0);
    endtask

    task automatic test_field_extremes;
        set_window('0);
        send_item(CMD_STORE, '0, '0);
        send_item(CMD_STORE, '1, '1);
        send_item(CMD_QUERY, '1, '0);
        send_item(CMD_QUERY, '0, '1);
        // window sum needs the 33rd bit here
        set_window('1);
        send_item(CMD_QUERY, '1, '0);
    endtask

    task automatic test_window_edges;
        set_window(32'd10);
        send_item(CMD_STORE, 32'd1000, 20'd5);
        send_item(CMD_STORE, 32'd1010, 20'd7);
        send_item(CMD_STORE, 32'd1020, 20'd3);
        send_item(CMD_QUERY, 32'd1030, '0);
        send_item(CMD_QUERY, 32'd1031, '0);
        send_item(CMD_QUERY, 32'd1020, '0);
    endtask

    task automatic test_out_of_order;
        send_item(CMD_STORE, 32'd5000, 20'd100);
        send_item(CMD_STORE, 32'd10, 20'd200);
        send_item(CMD_STORE, 32'd5002, 20'd50);
        // walk stops at the stale sample although an older one is inside
        send_item(CMD_QUERY, 32'd5005, '0);
        send_item(CMD_QUERY, 32'd15, '0);
    endtask

    task automatic run_phase(input bit [TIME_W-1:0] w, input int count);
        bit [TIME_W-1:0]  clock_ms;
        bit [TIME_W-1:0]  span;
        bit [POWER_W-1:0] p;
        int               roll;
        int               pick;
        clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
                                               : $urandom;
        span = (w > 3000) ? 3000 : w;
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                steady = ($urandom_range(0, 2) == 0);
            end
            pick = $urandom_range(0, 9);
            p = (pick == 0) ? '0 : (pick == 1) ? '1 : POWER_W'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                send_item(t_cmd'($urandom_range(0, 1)), $urandom, POWER_W'($urandom));
            end else if (roll < 70) begin
                clock_ms += $urandom_range(0, 20);
                send_item(CMD_STORE, clock_ms, p);
            end else if (roll < 75) begin
                send_item(CMD_STORE, clock_ms - $urandom_range(0, 2 * span + 40), p);
            end else begin
                send_item(CMD_QUERY, clock_ms + $urandom_range(0, span + 40),
                          POWER_W'($urandom));
            end
        end
        steady = 1'b0;
    endtask

    task automatic test_random_traffic;
        bit [TIME_W-1:0] windows [6];
        windows[0] = 32'd1;
        windows[1] = '1;
        windows[2] = $urandom_range(2, 300);
        windows[3] = '0;
        windows[4] = $urandom;
        windows[5] = 32'd2000;
        for (int ph = 0; ph < 6; ph++) begin
            set_window(windows[ph]);
            run_phase(windows[ph], PHASE_ITEMS);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_ring();
        test_field_extremes();
        test_window_edges();
        test_out_of_order();
        test_random_traffic();
        settle();
        if (mismatches == 0) begin
            $display("windowed_power_statistics: match");
        end else begin
            $display("windowed_power_statistics: mismatch");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/wps_pkg.sv
rtl/wps_ram.sv
rtl/wps_div.sv
rtl/windowed_power_statistics.sv
test/tb_top.sv
